[sv/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define TSRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TSRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/tsrs_pkg.sv]
// Shared types, register indexes, reset values and operation codes
// for the time sync retry scheduler. No dependencies.
`default_nettype none

package tsrs_pkg;

    localparam int unsigned STREAK_W = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 112;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_INTERVAL = 3'd0,
        REG_SYNC_TIMEOUT  = 3'd1,
        REG_RETRY_BASE    = 3'd2,
        REG_RETRY_MAX     = 3'd3,
        REG_EPOCH_FLOOR   = 3'd4,
        REG_DUP_WINDOW    = 3'd5
    } cfg_idx_t;

    // Event kinds carried on the input tuser
    typedef enum logic [S_TUSER_W-1:0] {
        OP_TICK   = 2'd0,
        OP_NOTICE = 2'd1,
        OP_MANUAL = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [31:0] SYNC_INTERVAL_RST = 32'd21600000;
    localparam logic [31:0] SYNC_TIMEOUT_RST  = 32'd60000;
    localparam logic [31:0] RETRY_BASE_RST    = 32'd15000;
    localparam logic [31:0] RETRY_MAX_RST     = 32'd900000;
    localparam logic [31:0] EPOCH_FLOOR_RST   = 32'd1704067200;
    localparam logic [7:0]  DUP_WINDOW_RST    = 8'd2;

    typedef struct packed {
        logic [31:0] sync_interval_ms;
        logic [31:0] sync_timeout_ms;
        logic [31:0] retry_base_ms;
        logic [31:0] retry_max_ms;
        logic [31:0] valid_epoch_floor;
        logic [7:0]  duplicate_window_s;
    } cfg_t;

    // Saturating increment of the failure streak
    function automatic logic [STREAK_W-1:0] streak_inc(input logic [STREAK_W-1:0] s);
        return (s == {STREAK_W{1'b1}}) ? s : s + {{(STREAK_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

[sv/tsrs_cfg.sv]
// Configuration register file of the scheduler.
// Depends on tsrs_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module tsrs_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic [tsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tsrs_pkg::CFG_DATA_W-1:0] cfg_data,
    output tsrs_pkg::cfg_t                       cfg
);
    import tsrs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write transaction; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SYNC_INTERVAL: cfg_next.sync_interval_ms   = cfg_data;
                REG_SYNC_TIMEOUT:  cfg_next.sync_timeout_ms    = cfg_data;
                REG_RETRY_BASE:    cfg_next.retry_base_ms      = cfg_data;
                REG_RETRY_MAX:     cfg_next.retry_max_ms       = cfg_data;
                REG_EPOCH_FLOOR:   cfg_next.valid_epoch_floor  = cfg_data;
                REG_DUP_WINDOW:    cfg_next.duplicate_window_s = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers; load defaults at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_interval_ms   <= SYNC_INTERVAL_RST;
            cfg_reg.sync_timeout_ms    <= SYNC_TIMEOUT_RST;
            cfg_reg.retry_base_ms      <= RETRY_BASE_RST;
            cfg_reg.retry_max_ms       <= RETRY_MAX_RST;
            cfg_reg.valid_epoch_floor  <= EPOCH_FLOOR_RST;
            cfg_reg.duplicate_window_s <= DUP_WINDOW_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/tsrs_backoff.sv]
// Retry delay: min(base << (streak-1), max), as a saturating barrel shift.
// Depends on tsrs_pkg for the streak width.
`default_nettype none

module tsrs_backoff (
    input  wire logic [tsrs_pkg::STREAK_W-1:0] streak,
    input  wire logic [31:0]                   retry_base,
    input  wire logic [31:0]                   retry_max,
    output logic      [31:0]                   delay
);
    import tsrs_pkg::*;

    logic [STREAK_W-1:0] shift;
    logic [63:0]         wide;

    // Shift in a 64-bit word so overflow shows up in the upper half
    always_comb begin
        shift = (streak != '0) ? streak - {{(STREAK_W-1){1'b0}}, 1'b1} : '0;
        wide  = {32'd0, retry_base} << shift[4:0];
        if (shift >= STREAK_W'(32)) begin
            delay = (retry_base != 32'd0) ? retry_max : 32'd0;
        end else if (wide > {32'd0, retry_max}) begin
            delay = retry_max;
        end else begin
            delay = wide[31:0];
        end
    end

endmodule

`default_nettype wire

[sv/time_sync_retry_scheduler_top.sv]
// Time sync retry scheduler: usage
// Input stream s_*: one event per transaction. s_tuser carries the event kind
// (0 tick, 1 sync notice, 2 manual set, 3 no-op). s_tdata carries the event
// fields. Output stream m_*: exactly one result transaction per event, in order.
// Config channel cfg_*: writes one register per transaction, always ready;
// write only while no event is in flight.
// An accepted event waits in the input register, then moves into the result
// register that drives m_*. Throughput: one event per cycle while m_tready
// keeps up. Each event is one pass of logic from input to result register;
// the scheduler state updates on that move, so the next event sees it.
// Reset (aresetn low, synchronous): both stages empty, configuration back to
// defaults, scheduler state cleared with boot request pending.
// When the receiver stalls, the result register holds; the input register
// still takes one more event, then s_tready drops until the result drains.
// Depends on tsrs_pkg, tsrs_cfg, tsrs_backoff and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module time_sync_retry_scheduler_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input event stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] now_ms, [63:32] epoch_value, [64] link_up, [65] has_address,
    // [66] sync_complete, [67] settings_changed, [68] dns_ok, [71:69] zero
    input  wire logic [tsrs_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  wire logic [tsrs_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] request_started, [1] failure_recorded, [2] sync_recorded,
    // [34:3] drift_seconds, [66:35] synced_epoch, [98:67] retry_delay_ms,
    // [106:99] streak_out, [107] busy_res, [108] synchronized,
    // [109] manual_accepted, [111:110] zero
    output logic      [tsrs_pkg::M_TDATA_W-1:0]  m_tdata,
    // Configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tsrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tsrs_pkg::*;

    cfg_t cfg;

    // Input register
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [31:0] in_now_reg;
    logic [31:0] in_epoch_reg;
    logic        in_link_reg;
    logic        in_done_reg;
    logic        in_changed_reg;
    logic        in_dns_reg;

    // Scheduler state
    logic                ip_reg, ip_next;
    logic                boot_reg, boot_next;
    logic                lwu_reg, lwu_next;
    logic [STREAK_W-1:0] streak_reg, streak_next;
    logic [31:0]         next_at_reg, next_at_next;
    logic [31:0]         dl_reg, dl_next;
    logic [31:0]         req_reg, req_next;
    logic [31:0]         lse_reg, lse_next;

    // Result register
    logic                out_valid_reg;
    logic                started_reg, started_next;
    logic                failed_reg, failed_next;
    logic                synced_reg, synced_next;
    logic [31:0]         drift_reg, drift_next;
    logic [31:0]         delay_reg, delay_next;
    logic                manual_reg, manual_next;
    logic                sync_ok_reg, sync_ok_next;

    logic                advance;
    logic                tick_ip;
    logic                timeout_hit;
    logic [STREAK_W-1:0] streak_p1;
    logic [31:0]         delay_a;
    logic [31:0]         delay_b;

    function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
        logic [31:0] diff;
        diff = now - t;
        return !diff[31];
    endfunction

    // Synced minus requested epoch, saturated to int32, zero unless both valid
    function automatic logic [31:0] drift_of(input logic [31:0] synced,
                                             input logic [31:0] req,
                                             input logic [31:0] floor);
        logic [32:0] d;
        d = {1'b0, synced} - {1'b0, req};
        if (!(synced >= floor && req >= floor)) begin
            return 32'd0;
        end else if (d[32] != d[31]) begin
            return d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            return d[31:0];
        end
    endfunction

    assign cfg_ready = 1'b1;

    tsrs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the event on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Streak after the running-request phase of a tick
    assign tick_ip     = (in_op_reg == OP_TICK) && ip_reg;
    assign timeout_hit = reached(in_now_reg, dl_reg);
    assign streak_p1   = (tick_ip && in_done_reg) ? '0 :
                         (tick_ip && in_link_reg && timeout_hit) ? streak_inc(streak_reg) :
                         streak_reg;

    // Backoff for the timeout failure and for a failed (re)start
    tsrs_backoff u_backoff_a (
        .streak     (streak_inc(streak_reg)),
        .retry_base (cfg.retry_base_ms),
        .retry_max  (cfg.retry_max_ms),
        .delay      (delay_a)
    );

    tsrs_backoff u_backoff_b (
        .streak     (streak_inc(streak_p1)),
        .retry_base (cfg.retry_base_ms),
        .retry_max  (cfg.retry_max_ms),
        .delay      (delay_b)
    );

    // Event processing
    always_comb begin
        logic        due;
        logic        want;
        logic [33:0] diff;
        logic [33:0] win;
        logic        dup;

        ip_next      = ip_reg;
        boot_next    = boot_reg;
        lwu_next     = lwu_reg;
        streak_next  = streak_reg;
        next_at_next = next_at_reg;
        dl_next      = dl_reg;
        req_next     = req_reg;
        lse_next     = lse_reg;
        started_next = 1'b0;
        failed_next  = 1'b0;
        synced_next  = 1'b0;
        drift_next   = 32'd0;
        delay_next   = 32'd0;
        manual_next  = 1'b0;
        due          = 1'b0;
        want         = 1'b0;
        diff         = {2'b00, in_epoch_reg} - {2'b00, lse_reg};
        win          = {26'd0, cfg.duplicate_window_s};
        dup          = 1'b0;

        unique case (in_op_reg)
            OP_TICK: begin
                // Resolve a running request: completion, link loss, timeout
                if (ip_reg) begin
                    if (in_done_reg) begin
                        drift_next   = drift_of(in_epoch_reg, req_reg,
                                                cfg.valid_epoch_floor);
                        synced_next  = 1'b1;
                        ip_next      = 1'b0;
                        dl_next      = 32'd0;
                        streak_next  = '0;
                        next_at_next = in_now_reg + cfg.sync_interval_ms;
                        lse_next     = in_epoch_reg;
                    end else if (!in_link_reg) begin
                        ip_next      = 1'b0;
                        dl_next      = 32'd0;
                        next_at_next = 32'd0;
                    end else if (timeout_hit) begin
                        ip_next      = 1'b0;
                        dl_next      = 32'd0;
                        streak_next  = streak_p1;
                        delay_next   = delay_a;
                        next_at_next = in_now_reg + delay_a;
                        failed_next  = 1'b1;
                    end
                end
                // Track the link and start a new request when one is wanted
                if (!in_link_reg) begin
                    lwu_next = 1'b0;
                end else begin
                    if (!lwu_reg) begin
                        lwu_next     = 1'b1;
                        boot_next    = 1'b1;
                        next_at_next = 32'd0;
                    end
                    due  = (next_at_next == 32'd0) || reached(in_now_reg, next_at_next);
                    want = !ip_next && (boot_next || due ||
                           (!(in_epoch_reg >= cfg.valid_epoch_floor) && streak_p1 == '0));
                    if (in_changed_reg || want) begin
                        req_next  = in_epoch_reg;
                        ip_next   = 1'b1;
                        boot_next = 1'b0;
                        if (!in_dns_reg) begin
                            ip_next      = 1'b0;
                            dl_next      = 32'd0;
                            streak_next  = streak_inc(streak_p1);
                            delay_next   = delay_b;
                            next_at_next = in_now_reg + delay_b;
                            failed_next  = 1'b1;
                        end else begin
                            dl_next      = in_now_reg + cfg.sync_timeout_ms;
                            started_next = 1'b1;
                        end
                    end
                end
            end
            OP_NOTICE: begin
                // Drop a notice that repeats the last success
                if (!ip_reg && lse_reg >= cfg.valid_epoch_floor) begin
                    dup = ($signed(diff) >= -$signed(win)) && ($signed(diff) <= $signed(win));
                end
                if (!dup) begin
                    drift_next   = drift_of(in_epoch_reg, req_reg, cfg.valid_epoch_floor);
                    synced_next  = 1'b1;
                    ip_next      = 1'b0;
                    dl_next      = 32'd0;
                    streak_next  = '0;
                    next_at_next = in_now_reg + cfg.sync_interval_ms;
                    lse_next     = in_epoch_reg;
                end
            end
            OP_MANUAL: begin
                // Accept a manual time only before the first valid sync
                if (!(lse_reg >= cfg.valid_epoch_floor) &&
                    in_epoch_reg >= cfg.valid_epoch_floor) begin
                    ip_next     = 1'b0;
                    dl_next     = 32'd0;
                    boot_next   = 1'b0;
                    manual_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        sync_ok_next = lse_next >= cfg.valid_epoch_floor;
    end

    // Control state: stage valid flags and scheduler state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ip_reg        <= 1'b0;
            boot_reg      <= 1'b1;
            lwu_reg       <= 1'b0;
            streak_reg    <= '0;
            next_at_reg   <= 32'd0;
            dl_reg        <= 32'd0;
            req_reg       <= 32'd0;
            lse_reg       <= 32'd0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                ip_reg        <= ip_next;
                boot_reg      <= boot_next;
                lwu_reg       <= lwu_next;
                streak_reg    <= streak_next;
                next_at_reg   <= next_at_next;
                dl_reg        <= dl_next;
                req_reg       <= req_next;
                lse_reg       <= lse_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture the input transaction
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg      <= op_t'(s_tuser);
            in_now_reg     <= s_tdata[31:0];
            in_epoch_reg   <= s_tdata[63:32];
            in_link_reg    <= s_tdata[64] & s_tdata[65];
            in_done_reg    <= s_tdata[66];
            in_changed_reg <= s_tdata[67];
            in_dns_reg     <= s_tdata[68];
        end
    end

    // Payload: load the result
    always_ff @(posedge aclk) begin
        if (advance) begin
            started_reg <= started_next;
            failed_reg  <= failed_next;
            synced_reg  <= synced_next;
            drift_reg   <= drift_next;
            delay_reg   <= delay_next;
            manual_reg  <= manual_next;
            sync_ok_reg <= sync_ok_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, manual_reg, sync_ok_reg, ip_reg, streak_reg, delay_reg,
                       lse_reg, drift_reg, synced_reg, failed_reg, started_reg};

    `TSRS_ASSERT(a_start_busy, aclk, aresetn, (m_tvalid && started_reg) |-> ip_reg, "request started but not busy")
    `TSRS_ASSERT(a_fail_streak, aclk, aresetn, (m_tvalid && failed_reg) |-> (streak_reg != '0), "failure with zero streak")
    `TSRS_ASSERT(a_sync_clear, aclk, aresetn, (m_tvalid && synced_reg && !failed_reg) |-> (streak_reg == '0), "sync left streak set")
    `TSRS_ASSERT(a_manual_unsync, aclk, aresetn, (m_tvalid && manual_reg) |-> !sync_ok_reg, "manual set while synchronized")
    `TSRS_ASSERT_ALWAYS(a_ready_free, aclk, !in_valid_reg |-> s_tready, "input stage empty but not ready")

endmodule

`default_nettype wire

[test/tb_time_sync_retry_scheduler_top.sv]
// Self-checking testbench for time_sync_retry_scheduler_top: streams tick, notice
// and manual-set events, predicts every result in a scoreboard and checks it.
// Depends on tsrs_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_time_sync_retry_scheduler_top;
    import tsrs_pkg::*;

    localparam logic [31:0] EPOCH_A   = 32'd1800000000;
    localparam longint      DRIFT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint      DRIFT_MIN = -64'sh0000_0000_8000_0000;

    // One event as offered on the input stream
    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [31:0] epoch;
        logic        link_up;
        logic        has_address;
        logic        sync_complete;
        logic        settings_changed;
        logic        dns_ok;
    } sched_event_t;

    // One result, laid out to match m_tdata[109:0]
    typedef struct packed {
        logic        manual_accepted;
        logic        synchronized;
        logic        busy;
        logic [7:0]  streak;
        logic [31:0] retry_delay_ms;
        logic [31:0] synced_epoch;
        logic [31:0] drift_seconds;
        logic        sync_recorded;
        logic        failure_recorded;
        logic        request_started;
    } sched_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    time_sync_retry_scheduler_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Scheduler shadow: configuration and state
    cfg_t        cfg_shadow;
    logic        sched_busy;
    logic        boot_pending;
    logic        link_was_up;
    logic [7:0]  fail_streak;
    logic [31:0] next_sync_at;
    logic [31:0] deadline_at;
    logic [31:0] requested_epoch;
    logic [31:0] last_success_epoch;

    sched_event_t  pending_events[$];
    sched_result_t predicted_outcomes[$];

    bit          in_taken;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;
    int          mismatch_count = 0;
    int          events_accepted = 0;
    int          results_checked = 0;
    int          settings_applied = 0;
    int          storm_events = 0;
    logic [31:0] gen_now = 0;
    logic [31:0] gen_epoch = 0;
    logic [31:0] gen_synced = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("time_sync_retry_scheduler_top test failed");
        $finish;
    end

    function automatic bit epoch_valid(input logic [31:0] e);
        return e >= cfg_shadow.valid_epoch_floor;
    endfunction

    // Wrapped difference read as signed 32 bits
    function automatic bit time_reached(input logic [31:0] now, input logic [31:0] t);
        logic [31:0] diff;
        diff = now - t;
        return !diff[31];
    endfunction

    // Count a timeout or DNS failure and reschedule with capped backoff
    task automatic count_failure(input logic [31:0] now, inout sched_result_t r);
        logic [7:0]  shift;
        logic [63:0] delay;
        sched_busy = 1'b0;
        deadline_at = '0;
        if (fail_streak != 8'hFF) fail_streak = fail_streak + 8'd1;
        shift = fail_streak - 8'd1;
        if (shift >= 8'd32)
            delay = (cfg_shadow.retry_base_ms != 0) ? {32'd0, cfg_shadow.retry_max_ms} : 64'd0;
        else
            delay = {32'd0, cfg_shadow.retry_base_ms} << shift;
        if (delay > {32'd0, cfg_shadow.retry_max_ms}) delay = {32'd0, cfg_shadow.retry_max_ms};
        r.retry_delay_ms = delay[31:0];
        next_sync_at = now + delay[31:0];
        r.failure_recorded = 1'b1;
    endtask

    // Record a success; drift only when both epochs are valid, clamped to int32
    task automatic record_sync(input logic [31:0] now, input logic [31:0] synced,
                               inout sched_result_t r);
        longint gap;
        gap = 0;
        if (epoch_valid(requested_epoch) && epoch_valid(synced)) begin
            gap = longint'({32'd0, synced}) - longint'({32'd0, requested_epoch});
            if (gap > DRIFT_MAX) gap = DRIFT_MAX;
            if (gap < DRIFT_MIN) gap = DRIFT_MIN;
        end
        r.drift_seconds = gap[31:0];
        r.sync_recorded = 1'b1;
        sched_busy = 1'b0;
        deadline_at = '0;
        fail_streak = '0;
        next_sync_at = now + cfg_shadow.sync_interval_ms;
        last_success_epoch = synced;
    endtask

    // Advance the shadow scheduler by one event and return its result
    task automatic schedule_event(input sched_event_t ev, output sched_result_t r);
        logic   link;
        logic   due;
        logic   want;
        logic   dup;
        longint diff;
        longint w;
        r = '0;
        link = ev.link_up && ev.has_address;
        case (ev.op)
            OP_TICK: begin
                if (sched_busy) begin
                    if (ev.sync_complete) begin
                        record_sync(ev.now_ms, ev.epoch, r);
                    end else if (!link) begin
                        sched_busy = 1'b0;
                        deadline_at = '0;
                        next_sync_at = '0;
                    end else if (time_reached(ev.now_ms, deadline_at)) begin
                        count_failure(ev.now_ms, r);
                    end
                end
                if (!link) begin
                    link_was_up = 1'b0;
                end else begin
                    if (!link_was_up) begin
                        link_was_up = 1'b1;
                        boot_pending = 1'b1;
                        next_sync_at = '0;
                    end
                    due = (next_sync_at == 0) || time_reached(ev.now_ms, next_sync_at);
                    want = !sched_busy && (boot_pending || due ||
                           (!epoch_valid(ev.epoch) && fail_streak == 0));
                    if (ev.settings_changed || want) begin
                        requested_epoch = ev.epoch;
                        sched_busy = 1'b1;
                        boot_pending = 1'b0;
                        deadline_at = ev.now_ms + cfg_shadow.sync_timeout_ms;
                        if (!ev.dns_ok) count_failure(ev.now_ms, r);
                        else r.request_started = 1'b1;
                    end
                end
            end
            OP_NOTICE: begin
                dup = 1'b0;
                if (!sched_busy && epoch_valid(last_success_epoch)) begin
                    diff = longint'({32'd0, ev.epoch}) - longint'({32'd0, last_success_epoch});
                    w = longint'({56'd0, cfg_shadow.duplicate_window_s});
                    dup = (diff >= -w) && (diff <= w);
                end
                if (!dup) record_sync(ev.now_ms, ev.epoch, r);
            end
            OP_MANUAL: begin
                if (!epoch_valid(last_success_epoch) && epoch_valid(ev.epoch)) begin
                    sched_busy = 1'b0;
                    deadline_at = '0;
                    boot_pending = 1'b0;
                    r.manual_accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.synced_epoch = last_success_epoch;
        r.streak = fail_streak;
        r.busy = sched_busy;
        r.synchronized = epoch_valid(last_success_epoch);
    endtask

    function automatic string result_text(input sched_result_t r);
        return $sformatf({"start=%0b fail=%0b sync=%0b drift=%0d epoch=%0d delay=%0d ",
                          "streak=%0d busy=%0b synced=%0b manual=%0b"},
                         r.request_started, r.failure_recorded, r.sync_recorded,
                         $signed(r.drift_seconds), r.synced_epoch, r.retry_delay_ms,
                         r.streak, r.busy, r.synchronized, r.manual_accepted);
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t ns: %s", $time, what);
    endtask

    // Scoreboard: check results, predict accepted events, track register writes
    always @(posedge aclk) begin : scoreboard
        sched_event_t  ev;
        sched_result_t got;
        sched_result_t exp_r;
        if (!aresetn) begin
            cfg_shadow.sync_interval_ms   = SYNC_INTERVAL_RST;
            cfg_shadow.sync_timeout_ms    = SYNC_TIMEOUT_RST;
            cfg_shadow.retry_base_ms      = RETRY_BASE_RST;
            cfg_shadow.retry_max_ms       = RETRY_MAX_RST;
            cfg_shadow.valid_epoch_floor  = EPOCH_FLOOR_RST;
            cfg_shadow.duplicate_window_s = DUP_WINDOW_RST;
            sched_busy = 1'b0;
            boot_pending = 1'b1;
            link_was_up = 1'b0;
            fail_streak = '0;
            next_sync_at = '0;
            deadline_at = '0;
            requested_epoch = '0;
            last_success_epoch = '0;
            in_taken = 1'b0;
        end else begin
            // Compare each result transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = sched_result_t'(m_tdata[109:0]);
                results_checked++;
                if (predicted_outcomes.size() == 0) begin
                    log_mismatch({"result with nothing predicted: ", result_text(got)});
                end else begin
                    exp_r = predicted_outcomes.pop_front();
                    if (got !== exp_r)
                        log_mismatch({"result mismatch\n  expected ", result_text(exp_r),
                                      "\n  actual   ", result_text(got)});
                end
            end
            // Predict from what was actually accepted on the pins
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                ev.op               = op_t'(s_tuser);
                ev.now_ms           = s_tdata[31:0];
                ev.epoch            = s_tdata[63:32];
                ev.link_up          = s_tdata[64];
                ev.has_address      = s_tdata[65];
                ev.sync_complete    = s_tdata[66];
                ev.settings_changed = s_tdata[67];
                ev.dns_ok           = s_tdata[68];
                schedule_event(ev, exp_r);
                predicted_outcomes.push_back(exp_r);
                events_accepted++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    REG_SYNC_INTERVAL: cfg_shadow.sync_interval_ms = cfg_data;
                    REG_SYNC_TIMEOUT:  cfg_shadow.sync_timeout_ms = cfg_data;
                    REG_RETRY_BASE:    cfg_shadow.retry_base_ms = cfg_data;
                    REG_RETRY_MAX:     cfg_shadow.retry_max_ms = cfg_data;
                    REG_EPOCH_FLOOR:   cfg_shadow.valid_epoch_floor = cfg_data;
                    REG_DUP_WINDOW:    cfg_shadow.duplicate_window_s = cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Event driver: offer the next queued event, idling at random
    always @(negedge aclk) begin : event_driver
        sched_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                ev = pending_events.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= ev.op;
                s_tdata <= {3'b000, ev.dns_ok, ev.settings_changed, ev.sync_complete,
                            ev.has_address, ev.link_up, ev.epoch, ev.now_ms};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin : result_receiver
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic sched_event_t make_event(input op_t op, input logic [31:0] now,
                                                input logic [31:0] epoch, input bit link,
                                                input bit addr, input bit done,
                                                input bit changed, input bit dns);
        sched_event_t ev;
        ev.op = op;
        ev.now_ms = now;
        ev.epoch = epoch;
        ev.link_up = link;
        ev.has_address = addr;
        ev.sync_complete = done;
        ev.settings_changed = changed;
        ev.dns_ok = dns;
        return ev;
    endfunction

    task automatic write_register(input cfg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Write every register, then restart the event timeline near the floor
    task automatic apply_settings(input logic [31:0] interval, input logic [31:0] timeout,
                                  input logic [31:0] base, input logic [31:0] cap,
                                  input logic [31:0] floor, input logic [7:0] window);
        write_register(REG_SYNC_INTERVAL, interval);
        write_register(REG_SYNC_TIMEOUT, timeout);
        write_register(REG_RETRY_BASE, base);
        write_register(REG_RETRY_MAX, cap);
        write_register(REG_EPOCH_FLOOR, floor);
        write_register(REG_DUP_WINDOW, {24'd0, window});
        settings_applied++;
        gen_epoch = floor + $urandom_range(0, 100000);
        gen_synced = gen_epoch;
    endtask

    // Hold off until the input queue is empty and every result has come back
    task automatic wait_idle();
        while (pending_events.size() != 0 || s_tvalid || predicted_outcomes.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Back-to-back failed restarts: drive the streak into saturation
    task automatic queue_storm(input int count);
        for (int i = 0; i < count; i++) begin
            gen_now = gen_now + $urandom_range(1, 10);
            pending_events.push_back(make_event(OP_TICK, gen_now, gen_epoch, 1, 1, 0, 1, 0));
            storm_events++;
        end
    endtask

    // Mostly coherent timelines with random content, plus some noise
    task automatic queue_random(input int count);
        sched_event_t ev;
        int           kind;
        int           w;
        logic [31:0]  advance;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            ev = make_event(op_t'($urandom_range(0, 3)), $urandom, $urandom,
                            $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 1));
            if (kind < 12) begin
                // leave as pure noise
            end else if (kind < 15) begin
                ev.op = OP_NONE;
            end else if (kind < 21) begin
                ev.op = OP_MANUAL;
                if ($urandom_range(0, 1)) ev.epoch = gen_epoch;
            end else if (kind < 38) begin
                ev.op = OP_NOTICE;
                ev.now_ms = gen_now;
                w = int'(cfg_shadow.duplicate_window_s);
                if ($urandom_range(0, 4) != 0)
                    ev.epoch = gen_synced + (int'($urandom_range(0, 2 * w + 4)) - (w + 2));
                gen_synced = ev.epoch;
            end else begin
                case ($urandom_range(0, 4))
                    0: advance = $urandom_range(0, 50);
                    1: advance = cfg_shadow.sync_timeout_ms - (cfg_shadow.sync_timeout_ms >> 3)
                                 + $urandom_range(0, cfg_shadow.sync_timeout_ms >> 2);
                    2: advance = $urandom_range(0, cfg_shadow.retry_max_ms);
                    3: advance = $urandom_range(0, cfg_shadow.sync_interval_ms);
                    default: advance = $urandom;
                endcase
                gen_now = gen_now + advance;
                gen_epoch = gen_epoch + advance / 1000;
                ev = make_event(OP_TICK, gen_now, gen_epoch, $urandom_range(0, 99) < 92,
                                $urandom_range(0, 99) < 95, $urandom_range(0, 99) < 25,
                                $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 85);
                if ($urandom_range(0, 99) < 6 && cfg_shadow.valid_epoch_floor != 0)
                    ev.epoch = $urandom_range(0, cfg_shadow.valid_epoch_floor - 1);
                if (ev.sync_complete) gen_synced = ev.epoch;
            end
            pending_events.push_back(ev);
        end
    endtask

    // Directed opening: boot, duplicates, link loss, wrap to zero, double failure,
    // restarts while busy, manual sets, invalid epochs and drift saturation
    task automatic queue_directed();
        pending_events.push_back(make_event(OP_TICK, 1000, EPOCH_A, 1, 1, 0, 0, 1));
        pending_events.push_back(make_event(OP_TICK, 2000, EPOCH_A + 5, 1, 1, 1, 0, 1));
        pending_events.push_back(make_event(OP_NOTICE, 2100, EPOCH_A + 6, 0, 0, 0, 0, 0));
        pending_events.push_back(make_event(OP_NOTICE, 2200, EPOCH_A + 3, 0, 0, 0, 0, 0));
        pending_events.push_back(make_event(OP_NOTICE, 2300, EPOCH_A + 8, 0, 0, 0, 0, 0));
        pending_events.push_back(make_event(OP_MANUAL, 2400, EPOCH_A, 1, 1, 0, 0, 1));
        pending_events.push_back(make_event(OP_NONE, '1, '1, 1, 1, 1, 1, 1));
        pending_events.push_back(make_event(OP_TICK, 3000, EPOCH_A, 0, 1, 0, 0, 1));
        pending_events.push_back(make_event(OP_TICK, 3001, EPOCH_A, 1, 0, 0, 0, 1));
        // failure whose retry time wraps to exactly zero
        pending_events.push_back(make_event(OP_TICK, 32'hFFFF_C568, EPOCH_A, 1, 1, 0, 0, 0));
        pending_events.push_back(make_event(OP_TICK, 32'hFFFF_C569, EPOCH_A, 1, 1, 0, 0, 1));
        pending_events.push_back(make_event(OP_TICK, 32'hFFFF_C56A, EPOCH_A, 0, 1, 0, 0, 1));
        pending_events.push_back(make_event(OP_TICK, 100, EPOCH_A, 1, 1, 0, 0, 1));
        // timeout and a failed restart in the same tick
        pending_events.push_back(make_event(OP_TICK, 60100, EPOCH_A, 1, 1, 0, 1, 0));
        pending_events.push_back(make_event(OP_TICK, 200001, EPOCH_A, 1, 1, 0, 1, 1));
        pending_events.push_back(make_event(OP_TICK, 200002, EPOCH_A, 1, 1, 0, 1, 1));
        pending_events.push_back(make_event(OP_TICK, 200003, 32'd1000, 1, 1, 1, 0, 1));
        pending_events.push_back(make_event(OP_MANUAL, 200004, EPOCH_A, 0, 0, 0, 0, 0));
        pending_events.push_back(make_event(OP_MANUAL, 200005, 32'd5, 0, 0, 0, 0, 0));
        pending_events.push_back(make_event(OP_TICK, '1, '1, 1, 1, 1, 1, 1));
        pending_events.push_back(make_event(OP_NOTICE, '0, '0, 0, 0, 0, 0, 0));
        // drift clamped at both ends
        pending_events.push_back(make_event(OP_TICK, 300000, EPOCH_FLOOR_RST, 1, 1, 0, 1, 1));
        pending_events.push_back(make_event(OP_NOTICE, 300001, '1, 1, 1, 0, 0, 1));
        pending_events.push_back(make_event(OP_TICK, 300002, '1, 1, 1, 0, 1, 1));
        pending_events.push_back(make_event(OP_NOTICE, 300003, EPOCH_FLOOR_RST, 1, 1, 0, 0, 1));
    endtask

    // Phase sequencing
    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 24;
        recv_idle_pct = 62;
        queue_directed();
        wait_idle();

        apply_settings(32'd5000, 32'd300, 32'd50, 32'd2000, 32'd1000000, 8'd5);
        queue_random(100);
        wait_idle();
        queue_random(100);
        wait_idle();

        send_idle_pct = 62;
        recv_idle_pct = 24;
        apply_settings('1, '1, '1, '1, '1, 8'hFF);
        queue_random(120);
        wait_idle();

        apply_settings(32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 8'd0);
        queue_random(80);
        queue_storm(40);
        queue_random(40);
        wait_idle();

        // base large enough that the shift passes the cap, streak driven past a 32-bit shift
        apply_settings(32'd100000, 32'd1000, 32'h4000_0000, '1, EPOCH_FLOOR_RST, 8'd2);
        queue_storm(300);
        queue_random(60);
        wait_idle();

        // no idling; long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(SYNC_INTERVAL_RST, SYNC_TIMEOUT_RST, 32'd0, 32'd500,
                       EPOCH_FLOOR_RST, DUP_WINDOW_RST);
        queue_random(100);
        hold_left = 300;
        wait_idle();
        queue_random(100);
        wait_idle();

        apply_settings(SYNC_INTERVAL_RST, SYNC_TIMEOUT_RST, RETRY_BASE_RST, RETRY_MAX_RST,
                       EPOCH_FLOOR_RST, DUP_WINDOW_RST);
        queue_random(120);
        wait_idle();
        repeat (10) @(posedge aclk);

        if (predicted_outcomes.size() != 0)
            log_mismatch($sformatf("%0d predicted results never arrived",
                                   predicted_outcomes.size()));
        $display("Checked %0d results for %0d events under %0d register settings;",
                 results_checked, events_accepted, settings_applied + 1);
        $display("%0d failure-storm ticks, idle mixes, and a long output stall included.",
                 storm_events);
        if (mismatch_count == 0) begin
            $display("time_sync_retry_scheduler_top test passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("time_sync_retry_scheduler_top test failed");
        end
        $finish;
    end

endmodule
